>>> sv/tspwm_pkg.sv
`timescale 1ns / 1ps
package tspwm_pkg;

  localparam int PHASE_BITS_DEF     = 16;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int POT_BITS_DEF       = 12;

  localparam logic [16:0] STEP_Q16   = 17'd655;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [16:0] TORQUE_RST = 17'd32768;
  localparam logic [15:0] PERIOD_RST = 16'd1000;
  localparam logic [16:0] HALF_Q16   = 17'd32768;

  localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
  localparam logic [31:0] SINE_SCALE     = 32'd32767;
  localparam logic [31:0] K1 = 32'd1686629714;
  localparam logic [31:0] K3 = 32'd693598669;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026992;
  localparam logic [31:0] K9 = 32'd172272;

  typedef enum logic [2:0] {
    EV_TICK, EV_SPEED_UP, EV_SPEED_DN, EV_REVERSE, EV_TORQUE_UP, EV_TORQUE_DN, EV_POT_TOGGLE
  } event_t;

  typedef enum logic [2:0] {A_POT, A_X, A_X2, A_T, A_SPEED} a_sel_t;

  typedef enum logic [2:0] {
    B_RECIP, B_X, B_K9, B_P, B_SCALE, B_TORQUE, B_PERIOD, B_INV
  } b_sel_t;

  typedef enum logic [3:0] {
    WB_NONE, WB_LATCH, WB_EVENT, WB_POT_Q, WB_POT_FIX, WB_ADDR, WB_X2, WB_POLY,
    WB_S, WB_U, WB_T, WB_DUTY, WB_ADV, WB_OUT
  } wb_t;

  typedef enum logic [1:0] {K_SEL1, K_SEL3, K_SEL5, K_SEL7} k_sel_t;

  typedef enum logic [2:0] {
    JC_NEXT, JC_WAIT_IN, JC_NOT_TICK, JC_NO_POT, JC_MORE_PH, JC_WAIT_OUT, JC_JUMP
  } jc_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EVENT, ST_POT_MUL, ST_POT_Q, ST_POT_FIX, ST_ADDR, ST_SQ_MUL, ST_X2,
    ST_K9_MUL, ST_P7, ST_P5_MUL, ST_P5, ST_P3_MUL, ST_P3, ST_P1_MUL, ST_P1,
    ST_S_MUL, ST_S, ST_V_MUL, ST_U, ST_TQ_MUL, ST_T, ST_PER_MUL, ST_DUTY,
    ST_ADV_MUL, ST_ADV, ST_DONE
  } step_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    wb_t    wb;
    k_sel_t k;
    jc_t    jc;
    step_t  target;
  } uword_t;

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{a: A_X, b: B_X, wb: WB_NONE, k: K_SEL1, jc: JC_NEXT, target: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        w.wb = WB_LATCH;
        w.jc = JC_WAIT_IN;
      end
      ST_EVENT: begin
        w.wb     = WB_EVENT;
        w.jc     = JC_NOT_TICK;
        w.target = ST_DONE;
      end
      ST_POT_MUL: begin
        w.a      = A_POT;
        w.b      = B_RECIP;
        w.jc     = JC_NO_POT;
        w.target = ST_ADDR;
      end
      ST_POT_Q:   w.wb = WB_POT_Q;
      ST_POT_FIX: w.wb = WB_POT_FIX;
      ST_ADDR:    w.wb = WB_ADDR;
      ST_SQ_MUL: begin
        w.a = A_X;
        w.b = B_X;
      end
      ST_X2:      w.wb = WB_X2;
      ST_K9_MUL: begin
        w.a = A_X2;
        w.b = B_K9;
      end
      ST_P7: begin
        w.wb = WB_POLY;
        w.k  = K_SEL7;
      end
      ST_P5_MUL: begin
        w.a = A_X2;
        w.b = B_P;
      end
      ST_P5: begin
        w.wb = WB_POLY;
        w.k  = K_SEL5;
      end
      ST_P3_MUL: begin
        w.a = A_X2;
        w.b = B_P;
      end
      ST_P3: begin
        w.wb = WB_POLY;
        w.k  = K_SEL3;
      end
      ST_P1_MUL: begin
        w.a = A_X2;
        w.b = B_P;
      end
      ST_P1: begin
        w.wb = WB_POLY;
        w.k  = K_SEL1;
      end
      ST_S_MUL: begin
        w.a = A_X;
        w.b = B_P;
      end
      ST_S:       w.wb = WB_S;
      ST_V_MUL: begin
        w.a = A_T;
        w.b = B_SCALE;
      end
      ST_U:       w.wb = WB_U;
      ST_TQ_MUL: begin
        w.a = A_T;
        w.b = B_TORQUE;
      end
      ST_T:       w.wb = WB_T;
      ST_PER_MUL: begin
        w.a = A_T;
        w.b = B_PERIOD;
      end
      ST_DUTY: begin
        w.wb     = WB_DUTY;
        w.jc     = JC_MORE_PH;
        w.target = ST_ADDR;
      end
      ST_ADV_MUL: begin
        w.a = A_SPEED;
        w.b = B_INV;
      end
      ST_ADV:     w.wb = WB_ADV;
      ST_DONE: begin
        w.wb     = WB_OUT;
        w.jc     = JC_WAIT_OUT;
        w.target = ST_IDLE;
      end
      default: begin
        w.jc     = JC_JUMP;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> sv/three_phase_sine_pwm_generator.sv
`timescale 1ns / 1ps
// One event is handled at a time: input is taken only in the idle step, and not again until
// its result has been registered for output. Non-tick events go straight to the output step.
// The tick time is set by the single shared 32x32 multiplier: 9 products per phase,
// each a multiply step and a writeback step, plus the pot and phase-advance products.
// Synchronous active-high reset: period 1000, torque one half; phase, speed, flags, duties zero.
module three_phase_sine_pwm_generator #(
  parameter int PHASE_BITS     = tspwm_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = tspwm_pkg::SINE_ADDR_BITS_DEF,
  parameter int POT_BITS       = tspwm_pkg::POT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,    // pwm_period
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,     // pot_sample[11:0]
  input  logic [2:0]  s_tuser,     // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata      // duty_a, duty_b, duty_c, speed_now, torque_now,
                                   // reversed, pot_active
);

  localparam int QB       = SINE_ADDR_BITS - 2;
  localparam int X_SH     = 30 - QB;
  localparam int SH       = 48 - PHASE_BITS;
  localparam int POT_FULL = (1 << POT_BITS) - 1;
  localparam int RECIP_SH = 16 + POT_BITS;
  localparam logic [63:0] POT_RECIP = (64'd1 << RECIP_SH) / 64'(POT_FULL);
  localparam logic [PHASE_BITS-1:0] OFF1 =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
  localparam logic [PHASE_BITS-1:0] OFF2 =
    PHASE_BITS'(((64'd2 << PHASE_BITS) + 64'd1) / 64'd3);

  tspwm_pkg::step_t  pc, pc_next;
  tspwm_pkg::uword_t uw;
  tspwm_pkg::event_t mode_r;

  logic [POT_BITS-1:0]   pot_r;
  logic [63:0]           prod;
  logic [30:0]           x, x2;
  logic [31:0]           p, t;
  logic                  sgn;
  logic [16:0]           q;
  logic [1:0]            ph;
  logic [PHASE_BITS-1:0] phase_acc;
  logic [16:0]           speed_reg, torque_reg;
  logic                  reverse_flag, pot_flag;
  logic [15:0]           last_duties [3];
  logic [15:0]           pwm_period;

  logic                  in_fire, out_busy;
  logic [31:0]           mul_a, mul_b, k_val;
  logic [15:0]           pot_ext;
  logic [33:0]           pot_rem;
  logic [PHASE_BITS-1:0] off_sel, ph_val, delta;
  logic [SINE_ADDR_BITS-1:0] addr;
  logic [QB:0]           pos;
  logic [63:0]           v_rnd, adv_rnd;
  logic [14:0]           v;
  logic [16:0]           u;
  logic [17:0]           spd_up, trq_up;

  assign uw        = tspwm_pkg::ucode(pc);
  assign s_tready  = (pc == tspwm_pkg::ST_IDLE);
  assign in_fire   = s_tvalid & s_tready;
  assign out_busy  = m_tvalid & ~m_tready;
  assign cfg_ready = 1'b1;
  assign pot_ext   = 16'(s_tdata[11:0]);

  always_comb begin
    pc_next = tspwm_pkg::step_t'(pc + 5'd1);
    unique case (uw.jc)
      tspwm_pkg::JC_NEXT:     ;
      tspwm_pkg::JC_WAIT_IN:  if (!in_fire) pc_next = pc;
      tspwm_pkg::JC_NOT_TICK: if (mode_r != tspwm_pkg::EV_TICK) pc_next = uw.target;
      tspwm_pkg::JC_NO_POT:   if (!pot_flag) pc_next = uw.target;
      tspwm_pkg::JC_MORE_PH:  if (ph != 2'd2) pc_next = uw.target;
      tspwm_pkg::JC_WAIT_OUT: pc_next = out_busy ? pc : uw.target;
      tspwm_pkg::JC_JUMP:     pc_next = uw.target;
      default:                ;
    endcase
  end

  always_comb begin
    case (uw.a)
      tspwm_pkg::A_POT:   mul_a = 32'({pot_r, 16'd0});
      tspwm_pkg::A_X:     mul_a = 32'(x);
      tspwm_pkg::A_X2:    mul_a = 32'(x2);
      tspwm_pkg::A_T:     mul_a = t;
      tspwm_pkg::A_SPEED: mul_a = 32'(speed_reg);
      default:            mul_a = 32'(x);
    endcase
    case (uw.b)
      tspwm_pkg::B_RECIP:  mul_b = POT_RECIP[31:0];
      tspwm_pkg::B_X:      mul_b = 32'(x);
      tspwm_pkg::B_K9:     mul_b = tspwm_pkg::K9;
      tspwm_pkg::B_P:      mul_b = p;
      tspwm_pkg::B_SCALE:  mul_b = tspwm_pkg::SINE_SCALE;
      tspwm_pkg::B_TORQUE: mul_b = 32'(torque_reg);
      tspwm_pkg::B_PERIOD: mul_b = 32'(pwm_period);
      tspwm_pkg::B_INV:    mul_b = tspwm_pkg::INV_TWO_PI_Q32;
      default:             mul_b = 32'(x);
    endcase
    case (uw.k)
      tspwm_pkg::K_SEL1: k_val = tspwm_pkg::K1;
      tspwm_pkg::K_SEL3: k_val = tspwm_pkg::K3;
      tspwm_pkg::K_SEL5: k_val = tspwm_pkg::K5;
      default:           k_val = tspwm_pkg::K7;
    endcase
  end

  // pot speed: q from reciprocal multiply is low by at most one
  assign pot_rem = 34'({pot_r, 16'd0}) - (34'(q) << POT_BITS) + 34'(q);

  always_comb begin
    case (ph)
      2'd1:    off_sel = OFF1;
      2'd2:    off_sel = OFF2;
      default: off_sel = '0;
    endcase
  end
  assign ph_val = phase_acc + off_sel;

  if (PHASE_BITS >= SINE_ADDR_BITS) begin : g_addr_dn
    assign addr = ph_val[PHASE_BITS-1 -: SINE_ADDR_BITS];
  end else begin : g_addr_up
    assign addr = {ph_val, {(SINE_ADDR_BITS - PHASE_BITS){1'b0}}};
  end

  assign pos = addr[SINE_ADDR_BITS-2] ? ({1'b1, {QB{1'b0}}} - {1'b0, addr[QB-1:0]})
                                      : {1'b0, addr[QB-1:0]};

  assign v_rnd = prod + 64'd536870912;
  assign v     = (v_rnd[46:30] > 17'd32767) ? 15'h7fff : v_rnd[44:30];
  assign u     = sgn ? (tspwm_pkg::HALF_Q16 - 17'(v)) : (tspwm_pkg::HALF_Q16 + 17'(v));

  assign adv_rnd = prod + (64'd1 << (SH - 1));
  assign delta   = adv_rnd[SH +: PHASE_BITS];

  assign spd_up = 18'(speed_reg) + 18'(tspwm_pkg::STEP_Q16);
  assign trq_up = 18'(torque_reg) + 18'(tspwm_pkg::STEP_Q16);

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
    if (rst) begin
      pc             <= tspwm_pkg::ST_IDLE;
      m_tvalid       <= 1'b0;
      phase_acc      <= '0;
      speed_reg      <= '0;
      torque_reg     <= tspwm_pkg::TORQUE_RST;
      reverse_flag   <= 1'b0;
      pot_flag       <= 1'b0;
      last_duties[0] <= '0;
      last_duties[1] <= '0;
      last_duties[2] <= '0;
      pwm_period     <= tspwm_pkg::PERIOD_RST;
      ph             <= '0;
    end else begin
      pc <= pc_next;
      if (cfg_valid) pwm_period <= cfg_data;
      if (m_tready && uw.wb != tspwm_pkg::WB_OUT) m_tvalid <= 1'b0;
      case (uw.wb)
        tspwm_pkg::WB_LATCH: begin
          if (in_fire) begin
            mode_r <= tspwm_pkg::event_t'(s_tuser);
            pot_r  <= pot_ext[POT_BITS-1:0];
          end
        end
        tspwm_pkg::WB_EVENT: begin
          ph <= '0;
          case (mode_r)
            tspwm_pkg::EV_SPEED_UP:
              speed_reg <= (spd_up > 18'(tspwm_pkg::ONE_Q16)) ? tspwm_pkg::ONE_Q16
                                                              : spd_up[16:0];
            tspwm_pkg::EV_SPEED_DN:
              speed_reg <= (speed_reg < tspwm_pkg::STEP_Q16) ? 17'd0
                                                             : speed_reg - tspwm_pkg::STEP_Q16;
            tspwm_pkg::EV_REVERSE: reverse_flag <= ~reverse_flag;
            tspwm_pkg::EV_TORQUE_UP:
              torque_reg <= (trq_up > 18'(tspwm_pkg::ONE_Q16)) ? tspwm_pkg::ONE_Q16
                                                               : trq_up[16:0];
            tspwm_pkg::EV_TORQUE_DN:
              torque_reg <= (torque_reg < tspwm_pkg::STEP_Q16) ? 17'd0
                                                               : torque_reg - tspwm_pkg::STEP_Q16;
            tspwm_pkg::EV_POT_TOGGLE: pot_flag <= ~pot_flag;
            default: ;
          endcase
        end
        tspwm_pkg::WB_POT_Q:   q <= prod[RECIP_SH +: 17];
        tspwm_pkg::WB_POT_FIX: speed_reg <= (pot_rem >= 34'(POT_FULL)) ? q + 17'd1 : q;
        tspwm_pkg::WB_ADDR: begin
          x   <= 31'({pos, {X_SH{1'b0}}});
          sgn <= addr[SINE_ADDR_BITS-1];
        end
        tspwm_pkg::WB_X2:   x2 <= prod[60:30];
        tspwm_pkg::WB_POLY: p <= k_val - prod[61:30];
        tspwm_pkg::WB_S:    t <= prod[61:30];
        tspwm_pkg::WB_U:    t <= 32'(u);
        tspwm_pkg::WB_T:    t <= prod[31:0];
        tspwm_pkg::WB_DUTY: begin
          last_duties[ph] <= prod[47:32];
          ph              <= ph + 2'd1;
        end
        tspwm_pkg::WB_ADV:
          phase_acc <= reverse_flag ? (phase_acc - delta) : (phase_acc + delta);
        tspwm_pkg::WB_OUT: begin
          if (!out_busy) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'd0, pot_flag, reverse_flag, torque_reg, speed_reg,
                         last_duties[2], last_duties[1], last_duties[0]};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_three_phase_sine_pwm_generator.sv
`timescale 1ns / 1ps
module tb_three_phase_sine_pwm_generator;

  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] EV_SPARE    = 3'd7;
  localparam logic [15:0] PHASE_OFS_B = 16'd21845;
  localparam logic [15:0] PHASE_OFS_C = 16'd43691;
  localparam logic [11:0] POT_FULL    = 12'hFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;

  three_phase_sine_pwm_generator uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  typedef struct {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [16:0] speed;
    logic [16:0] torque;
    logic        reversed;
    logic        pot_active;
  } drive_status_t;

  drive_status_t expected_drive[$];
  int mismatches = 0;
  int cycle_count = 0;
  int hold_req = 0;
  bit idle_on = 1'b1;

  // model state
  logic [15:0] period_q = tspwm_pkg::PERIOD_RST;
  logic [15:0] phase_q = '0;
  logic [16:0] speed_q = '0;
  logic [16:0] torque_q = tspwm_pkg::TORQUE_RST;
  logic        reverse_q = 1'b0;
  logic        pot_mode_q = 1'b0;
  logic [15:0] duty_q[3] = '{default: '0};

  initial forever #5 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Q15 sine from the quarter-wave polynomial
  function automatic int sine_q15(input logic [9:0] addr);
    logic [63:0] pos, x, x2, p, s, v;
    pos = addr[8] ? 64'd256 - 64'(addr[7:0]) : 64'(addr[7:0]);
    x   = pos << 22;
    x2  = (x * x) >> 30;
    p   = 64'(tspwm_pkg::K7) - ((x2 * 64'(tspwm_pkg::K9)) >> 30);
    p   = 64'(tspwm_pkg::K5) - ((x2 * p) >> 30);
    p   = 64'(tspwm_pkg::K3) - ((x2 * p) >> 30);
    p   = 64'(tspwm_pkg::K1) - ((x2 * p) >> 30);
    s   = (x * p) >> 30;
    v   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return addr[9] ? -int'(v) : int'(v);
  endfunction

  function automatic logic [15:0] duty_of(input logic [15:0] ph);
    logic [63:0] u, prod;
    u    = 64'(32768 + sine_q15(ph[15:6]));
    prod = u * 64'(torque_q) * 64'(period_q);
    return prod[47:32];
  endfunction

  function automatic void update_drive(input logic [2:0] mode, input logic [11:0] pot);
    logic [63:0]   step;
    logic [15:0]   delta;
    drive_status_t want;
    case (mode)
      tspwm_pkg::EV_TICK: begin
        if (pot_mode_q) begin
          step    = (64'(pot) << 16) / 64'(POT_FULL);
          speed_q = (step > 64'(tspwm_pkg::ONE_Q16)) ? tspwm_pkg::ONE_Q16 : step[16:0];
        end
        duty_q[0] = duty_of(phase_q);
        duty_q[1] = duty_of(phase_q + PHASE_OFS_B);
        duty_q[2] = duty_of(phase_q + PHASE_OFS_C);
        step  = (64'(speed_q) * 64'(tspwm_pkg::INV_TWO_PI_Q32) + (64'd1 << 31)) >> 32;
        delta = step[15:0];
        phase_q = reverse_q ? phase_q - delta : phase_q + delta;
      end
      tspwm_pkg::EV_SPEED_UP:
        speed_q = (18'(speed_q) + 18'(tspwm_pkg::STEP_Q16) > 18'(tspwm_pkg::ONE_Q16))
                  ? tspwm_pkg::ONE_Q16 : speed_q + tspwm_pkg::STEP_Q16;
      tspwm_pkg::EV_SPEED_DN:
        speed_q = (speed_q < tspwm_pkg::STEP_Q16) ? '0 : speed_q - tspwm_pkg::STEP_Q16;
      tspwm_pkg::EV_REVERSE:    reverse_q = ~reverse_q;
      tspwm_pkg::EV_TORQUE_UP:
        torque_q = (18'(torque_q) + 18'(tspwm_pkg::STEP_Q16) > 18'(tspwm_pkg::ONE_Q16))
                   ? tspwm_pkg::ONE_Q16 : torque_q + tspwm_pkg::STEP_Q16;
      tspwm_pkg::EV_TORQUE_DN:
        torque_q = (torque_q < tspwm_pkg::STEP_Q16) ? '0 : torque_q - tspwm_pkg::STEP_Q16;
      tspwm_pkg::EV_POT_TOGGLE: pot_mode_q = ~pot_mode_q;
      default: ;
    endcase
    want.duty_a     = duty_q[0];
    want.duty_b     = duty_q[1];
    want.duty_c     = duty_q[2];
    want.speed      = speed_q;
    want.torque     = torque_q;
    want.reversed   = reverse_q;
    want.pot_active = pot_mode_q;
    expected_drive.push_back(want);
  endfunction

  task automatic compare_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_result
    drive_status_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.duty_a     = m_tdata[15:0];
      got.duty_b     = m_tdata[31:16];
      got.duty_c     = m_tdata[47:32];
      got.speed      = m_tdata[64:48];
      got.torque     = m_tdata[81:65];
      got.reversed   = m_tdata[82];
      got.pot_active = m_tdata[83];
      if (expected_drive.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = expected_drive.pop_front();
        compare_field("duty_a", 17'(want.duty_a), 17'(got.duty_a));
        compare_field("duty_b", 17'(want.duty_b), 17'(got.duty_b));
        compare_field("duty_c", 17'(want.duty_c), 17'(got.duty_c));
        compare_field("speed_now", want.speed, got.speed);
        compare_field("torque_now", want.torque, got.torque);
        compare_field("reversed", 17'(want.reversed), 17'(got.reversed));
        compare_field("pot_active", 17'(want.pot_active), 17'(got.pot_active));
      end
    end
  end

  // output backpressure; long holds are requested through hold_req
  always @(posedge clk) begin : drive_ready
    int stall_left;
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_event(input logic [2:0] mode, input logic [11:0] pot);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, pot};
    do @(posedge clk); while (!s_tready);
    update_drive(mode, pot);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_drive.size() != 0);
  endtask

  task automatic set_period(input logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_q = value;
  endtask

  function automatic logic [11:0] pick_pot();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 12'h000;
    if (r == 1) return POT_FULL;
    return 12'($urandom_range(0, 4095));
  endfunction

  task automatic test_directed();
    set_period(16'hFFFF);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(EV_SPARE, 12'hFFF);
    send_event(tspwm_pkg::EV_SPEED_UP, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(tspwm_pkg::EV_REVERSE, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);   // phase goes below zero and wraps
    send_event(tspwm_pkg::EV_POT_TOGGLE, 12'h000);
    send_event(tspwm_pkg::EV_TICK, POT_FULL);
    send_event(tspwm_pkg::EV_SPEED_UP, 12'h000);  // saturates at one
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(tspwm_pkg::EV_SPEED_DN, 12'h000);  // saturates at zero
    send_event(tspwm_pkg::EV_SPEED_UP, 12'h000);  // overwritten by next tick
    send_event(tspwm_pkg::EV_TICK, 12'hAAA);
    send_event(tspwm_pkg::EV_TICK, 12'h555);
    send_event(tspwm_pkg::EV_POT_TOGGLE, 12'h000);
    send_event(tspwm_pkg::EV_TORQUE_UP, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h123);
    send_event(tspwm_pkg::EV_TORQUE_DN, 12'h000);
    send_event(tspwm_pkg::EV_REVERSE, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(EV_SPARE, 12'h000);
  endtask

  task automatic test_zero_period();
    set_period(16'h0000);
    send_event(tspwm_pkg::EV_SPEED_UP, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    send_event(tspwm_pkg::EV_TORQUE_UP, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
  endtask

  task automatic test_torque_limits();
    set_period(tspwm_pkg::PERIOD_RST);
    repeat (55) send_event(tspwm_pkg::EV_TORQUE_DN, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    repeat (105) send_event(tspwm_pkg::EV_TORQUE_UP, 12'h000);
    send_event(tspwm_pkg::EV_TICK, 12'h000);
    repeat (50) send_event(tspwm_pkg::EV_TORQUE_DN, 12'h000);
  endtask

  // results pile up behind a long output hold and the input stalls
  task automatic test_backpressure();
    wait_drained();
    hold_req = 400;
    repeat (24) send_event(3'($urandom_range(0, 7)), pick_pot());
    wait_drained();
  endtask

  task automatic test_random(input int count, input logic [15:0] period);
    int n, pick, len;
    logic [2:0] mode;
    set_period(period);
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        case ($urandom_range(0, 3))
          0: mode = tspwm_pkg::EV_SPEED_UP;
          1: mode = tspwm_pkg::EV_SPEED_DN;
          2: mode = tspwm_pkg::EV_TORQUE_UP;
          default: mode = tspwm_pkg::EV_TORQUE_DN;
        endcase
        len = $urandom_range(5, 60);
        repeat (len) send_event(mode, pick_pot());
        n += len;
      end else if (pick < 62) begin
        send_event(tspwm_pkg::EV_TICK, pick_pot());
        n++;
      end else begin
        send_event(3'($urandom_range(1, 7)), pick_pot());
        n++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_zero_period();
    test_torque_limits();
    test_backpressure();
    test_random(250, 16'($urandom));
    test_random(250, 16'hFFFF);
    test_random(200, tspwm_pkg::PERIOD_RST);
    test_random(200, 16'h8000 | 16'($urandom_range(0, 32767)));
    idle_on = 1'b0;
    test_random(150, 16'($urandom));
    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0 && expected_drive.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/tspwm_pkg.sv
sv/three_phase_sine_pwm_generator.sv
tb/sv/tb_three_phase_sine_pwm_generator.sv
